// ----- design/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types, widths, register codes and saturation helpers for the
// biquad section.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int COEF_FRAC  = 16;
  localparam int STATE_W    = 24;
  localparam int STATE_FRAC = 4;
  localparam int NUM_REGS   = 7;
  localparam int IDX_W      = 3;

  // product, rounded product, accumulator, output pre-saturation widths
  localparam int PROD_W = COEF_W + STATE_W;
  localparam int RND_W  = PROD_W - COEF_FRAC;
  localparam int ACC_W  = RND_W + 4;
  localparam int OUTR_W = RND_W + 1 - STATE_FRAC;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RND_W-1:0]    rnd_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [OUTR_W-1:0]   outr_t;

  typedef enum logic [IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GIN  = 3'd5,
    REG_GOUT = 3'd6
  } reg_idx_e;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    coef_t'(0), coef_t'(16962), coef_t'(0), coef_t'(-126605),
    coef_t'(65536), coef_t'(65536), coef_t'(65536)
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_MUL_B1,
    ST_MUL_B2,
    ST_MUL_B0,
    ST_SAT_Y,
    ST_MUL_G,
    ST_DONE
  } seq_state_e;

  function automatic state_t sat_state(acc_t v);
    acc_t hi;
    acc_t lo;
    hi = acc_t'((2 ** (STATE_W - 1)) - 1);
    lo = -hi - acc_t'(1);
    if (v > hi) return state_t'(hi);
    else if (v < lo) return state_t'(lo);
    else return state_t'(v);
  endfunction

  function automatic sample_t sat_sample(outr_t v);
    outr_t hi;
    outr_t lo;
    hi = outr_t'((2 ** (SAMPLE_W - 1)) - 1);
    lo = -hi - outr_t'(1);
    if (v > hi) return sample_t'(hi);
    else if (v < lo) return sample_t'(lo);
    else return sample_t'(v);
  endfunction

endpackage

// ----- design/biquad_iir_section_unit.sv -----
// ----------------------------------------------------------------------------
// biquad_iir_section_unit
// Direct-form-II biquad section with input and output gain, fixed point,
// built around one shared multiplier and a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel     | direction | handshake                         | payload
//  ------------+-----------+-----------------------------------+---------------
//  sample_in   | in        | sample_in_valid_i/sample_in_ready_o | 16b signed
//  sample_out  | out       | sample_out_valid_o/sample_out_ready_i | 16b signed
//  cfg         | in        | cfg_we_i (no wait)                | idx 3b, 18b data
//
//  Each item runs from acceptance to the result register through six
//  multiply steps one after another on the single 18x24 multiplier,
//  a saturate step for y, the output-gain multiply and the output step.
//  The next item is taken in the idle state that follows.
//  Input is taken only in the idle state; a finished result sits in the
//  output register, so the next item can be taken while it waits.
//  If the previous result is still unclaimed at the end of an item, the
//  sequencer holds in its final step until the output register frees.
//  Reset (async, active low) clears the delay words, loads the register
//  reset values and empties the output register.
//
module biquad_iir_section_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_in_valid_i,
  output logic                   sample_in_ready_o,
  input  biq_pkg::sample_t       sample_in_i,
  output logic                   sample_out_valid_o,
  input  logic                   sample_out_ready_i,
  output biq_pkg::sample_t       sample_out_o,
  input  logic                   cfg_we_i,
  input  logic [biq_pkg::IDX_W-1:0] cfg_idx_i,
  input  biq_pkg::coef_t         cfg_wdata_i
);
  import biq_pkg::*;

  // configuration registers
  coef_t      coef_q [NUM_REGS];

  // sequencer and datapath state
  seq_state_e state_q, state_d;
  sample_t    samp_q;
  acc_t       acc_q, acc_d;
  state_t     w_q, w_d;
  state_t     dly_recent_q, dly_older_q;
  sample_t    out_q;
  logic       out_valid_q, out_valid_d;

  // shared multiplier controls
  logic       mul_en;
  coef_t      mul_coef;
  state_t     mul_opnd;
  rnd_t       mul_rnd;

  logic       in_acc;
  logic       out_load;
  acc_t       rnd_ext;
  logic signed [RND_W:0] g_bias;
  outr_t      g_shift;

  assign in_acc  = sample_in_valid_i && sample_in_ready_o;
  assign rnd_ext = acc_t'(mul_rnd);

  // output: round half up by the state fraction bits, then saturate
  assign g_bias  = (RND_W + 1)'(mul_rnd) + (RND_W + 1)'(2 ** (STATE_FRAC - 1));
  assign g_shift = outr_t'(g_bias[RND_W:STATE_FRAC]);

  // --------------------------------------------------------------------------
  // configuration writes; out-of-range index is dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (cfg_we_i && (cfg_idx_i < IDX_W'(NUM_REGS))) begin
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  biq_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .coef_i (mul_coef),
    .opnd_i (mul_opnd),
    .rnd_o  (mul_rnd)
  );

  // --------------------------------------------------------------------------
  // sequencer: each multiply step issues one multiply, and the step after it
  // folds in that product (the product register sits between them)
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    w_d         = w_q;
    mul_en      = 1'b0;
    mul_coef    = coef_q[REG_GIN];
    mul_opnd    = state_t'(samp_q) <<< STATE_FRAC;
    out_load    = 1'b0;
    sample_in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        sample_in_ready_o = 1'b1;
        if (sample_in_valid_i) begin
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        // x product: gain_in * sample in state format
        mul_en  = 1'b1;
        state_d = ST_MUL_A1;
      end
      ST_MUL_A1: begin
        acc_d    = acc_t'(sat_state(rnd_ext));
        mul_en   = 1'b1;
        mul_coef = coef_q[REG_A1];
        mul_opnd = dly_recent_q;
        state_d  = ST_MUL_A2;
      end
      ST_MUL_A2: begin
        acc_d    = acc_q - rnd_ext;
        mul_en   = 1'b1;
        mul_coef = coef_q[REG_A2];
        mul_opnd = dly_older_q;
        state_d  = ST_MUL_B1;
      end
      ST_MUL_B1: begin
        w_d      = sat_state(acc_q - rnd_ext);
        mul_en   = 1'b1;
        mul_coef = coef_q[REG_B1];
        mul_opnd = dly_recent_q;
        state_d  = ST_MUL_B2;
      end
      ST_MUL_B2: begin
        acc_d    = rnd_ext;
        mul_en   = 1'b1;
        mul_coef = coef_q[REG_B2];
        mul_opnd = dly_older_q;
        state_d  = ST_MUL_B0;
      end
      ST_MUL_B0: begin
        acc_d    = acc_q + rnd_ext;
        mul_en   = 1'b1;
        mul_coef = coef_q[REG_B0];
        mul_opnd = w_q;
        state_d  = ST_SAT_Y;
      end
      ST_SAT_Y: begin
        acc_d   = acc_t'(sat_state(acc_q + rnd_ext));
        state_d = ST_MUL_G;
      end
      ST_MUL_G: begin
        mul_en   = 1'b1;
        mul_coef = coef_q[REG_GOUT];
        mul_opnd = state_t'(acc_q);
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // wait here while the previous item is unclaimed
        if (!out_valid_q || sample_out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (sample_out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      dly_recent_q <= '0;
      dly_older_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        // delay line shifts once the item is done
        dly_older_q  <= dly_recent_q;
        dly_recent_q <= w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q <= sample_in_i;
    end
    acc_q <= acc_d;
    w_q   <= w_d;
    if (out_load) begin
      out_q <= sat_sample(g_shift);
    end
  end

  assign sample_out_valid_o = out_valid_q;
  assign sample_out_o       = out_q;

`ifndef NO_ASSERTIONS
  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !sample_in_ready_o)
    else $error("input taken again right after an accepted item");

  // a result only appears from the final sequencer step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the final step");

  // delay words move only when an item completes
  a_delay_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(dly_recent_q) |-> $past(out_load))
    else $error("delay word changed outside item completion");

  // a stalled output holds the sequencer in its final step
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !sample_out_ready_i) |=> state_q == ST_DONE)
    else $error("sequencer left final step while output stalled");
`endif

endmodule

// ----- design/biq_mul.sv -----
// ----------------------------------------------------------------------------
// biq_mul
// Shared signed multiplier, coefficient by state word, with registered
// product and round-half-up back to state format.
// ----------------------------------------------------------------------------
module biq_mul (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  biq_pkg::coef_t        coef_i,
  input  biq_pkg::state_t       opnd_i,
  output biq_pkg::rnd_t         rnd_o
);
  import biq_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_bias;

  assign prod_d = PROD_W'(coef_i) * PROD_W'(opnd_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // floor((p + half) / 2^frac); top bits are free since |p| < 2^41
  assign prod_bias = prod_q + PROD_W'(2 ** (COEF_FRAC - 1));
  assign rnd_o     = rnd_t'(prod_bias[PROD_W-1:COEF_FRAC]);

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: biquad_iir_section_unit bench
// Drives signed samples through the direct-form-II biquad under several
// coefficient sets, including reset values, rail values and random stable
// filters. Every output item is checked against an in-bench fixed-point
// model of the section. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import biq_pkg::*;

  // Index past the register file; a write to it must change nothing.
  localparam logic [IDX_W-1:0] IDX_NONE = 3'd7;

  localparam coef_t   COEF_MAX   = coef_t'(131071);
  localparam coef_t   COEF_MIN   = coef_t'(-131072);
  localparam coef_t   COEF_ONE   = coef_t'(65536);
  localparam sample_t SAMPLE_MAX = sample_t'(32767);
  localparam sample_t SAMPLE_MIN = sample_t'(-32768);

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 105;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  sample_t              in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [IDX_W-1:0]     cfg_idx   = '0;
  coef_t                cfg_wdata = '0;
  logic                 sample_in_ready_o;
  logic                 sample_out_valid_o;
  sample_t              sample_out_o;

  biquad_iir_section_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sample_in_valid_i  (in_valid),
    .sample_in_ready_o  (sample_in_ready_o),
    .sample_in_i        (in_data),
    .sample_out_valid_o (sample_out_valid_o),
    .sample_out_ready_i (out_ready),
    .sample_out_o       (sample_out_o),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Section model: coefficient copy, the two delay words, and the queues.
  // All arithmetic in 64 bits; products stay under 2^43.
  // --------------------------------------------------------------------------
  longint  tap_coef [NUM_REGS];
  longint  w_recent;
  longint  w_older;

  sample_t samples_to_send_q [$];
  sample_t filtered_due_q [$];

  int      n_accepted = 0;
  int      n_checked  = 0;
  int      n_rail     = 0;
  int      n_errors   = 0;
  int      n_settings = 1;

  // coef * v / 2^COEF_FRAC, rounded half toward +inf
  function automatic longint scale_round(longint coef, longint v);
    return (coef * v + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic longint clamp(longint v, int width);
    longint hi;
    longint lo;
    hi = (longint'(1) << (width - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One sample through the section; advances the delay line.
  function automatic sample_t filter_sample(sample_t s);
    longint x;
    longint w;
    longint y;
    longint g;
    x = clamp(scale_round(tap_coef[REG_GIN], longint'(s) * (longint'(1) << STATE_FRAC)),
              STATE_W);
    w = clamp(x - scale_round(tap_coef[REG_A1], w_recent)
                - scale_round(tap_coef[REG_A2], w_older), STATE_W);
    y = clamp(scale_round(tap_coef[REG_B0], w) + scale_round(tap_coef[REG_B1], w_recent)
              + scale_round(tap_coef[REG_B2], w_older), STATE_W);
    w_older  = w_recent;
    w_recent = w;
    // output gain back to state format, then drop the state fraction bits
    g = scale_round(tap_coef[REG_GOUT], y);
    g = (g + (longint'(1) << (STATE_FRAC - 1))) >>> STATE_FRAC;
    return sample_t'(clamp(g, SAMPLE_W));
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps (often none) in between.
  // Valid holds with stable data until the item is taken.
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && sample_in_ready_o) begin
        filtered_due_q.push_back(filter_sample(in_data));
        n_accepted++;
      end
      if (!in_valid || sample_in_ready_o) begin
        if (gap_left > 0 || samples_to_send_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_data  <= samples_to_send_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: alternating ready and stall runs; stalls are mostly short,
  // now and then long enough to back the sequencer up into its hold step.
  // --------------------------------------------------------------------------
  int      ready_run;
  sample_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      ready_run = 0;
    end else begin
      if (sample_out_valid_o && out_ready) begin
        if (filtered_due_q.size() == 0) begin
          $error("sample_out: unexpected item, actual %0d", sample_out_o);
          n_errors++;
        end else begin
          want = filtered_due_q.pop_front();
          n_checked++;
          if (want == SAMPLE_MAX || want == SAMPLE_MIN) n_rail++;
          if (sample_out_o !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, sample_out_o);
            n_errors++;
          end
        end
      end
      if (ready_run > 0) begin
        ready_run--;
      end else if (out_ready) begin
        out_ready <= 1'b0;
        ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b1;
        ready_run = $urandom_range(0, 40);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes and stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [IDX_W-1:0] idx, coef_t val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx < NUM_REGS) tap_coef[idx] = longint'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2,
                         coef_t g_in, coef_t g_out);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_GIN, g_in);
    write_reg(REG_GOUT, g_out);
    n_settings++;
  endtask

  function automatic coef_t rand_coef();
    return coef_t'($urandom);
  endfunction

  // Random stable section: a2 in [0, 0.9], |a1| at most 0.9 * (1 + a2).
  task automatic config_stable();
    int a2;
    int lim;
    int a1;
    a2  = $urandom_range(0, 58982);
    lim = (65536 + a2) * 9 / 10;
    a1  = int'($urandom_range(0, 2 * lim)) - lim;
    set_all(rand_coef(), rand_coef(), rand_coef(), coef_t'(a1), coef_t'(a2),
            coef_t'(int'($urandom_range(8192, 98304))), rand_coef());
  endtask

  // Sample runs: full-range noise, low-level signal, steps, impulses, and
  // rail-to-rail toggling.
  task automatic queue_samples(int count);
    int      kind;
    int      run;
    int      amp;
    int      k;
    sample_t hold;
    while (count > 0) begin
      kind = $urandom_range(0, 9);
      run  = $urandom_range(1, 16);
      if (run > count) run = count;
      hold = sample_t'($urandom);
      amp  = $urandom_range(1, 2048);
      for (k = 0; k < run; k++) begin
        case (kind)
          0, 1, 2, 3: samples_to_send_q.push_back(sample_t'($urandom));
          4, 5, 6:    samples_to_send_q.push_back(
                        sample_t'(int'($urandom_range(0, 2 * amp)) - amp));
          7:          samples_to_send_q.push_back(hold);
          8:          samples_to_send_q.push_back((k == 0) ? hold : sample_t'(0));
          default:    samples_to_send_q.push_back((k % 2 == 1) ? SAMPLE_MAX : SAMPLE_MIN);
        endcase
      end
      count -= run;
    end
  endtask

  // Wait until the block has nothing in flight, then a short settle.
  // Sampled on the falling edge to stay clear of the driver's updates.
  task automatic drain();
    do @(negedge clk_i);
    while (samples_to_send_q.size() != 0 || in_valid || filtered_due_q.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NUM_REGS; i++) tap_coef[i] = longint'(COEF_RESET[i]);
    w_recent = 0;
    w_older  = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out-of-range index: must be dropped, reset coefficients stay live
    write_reg(IDX_NONE, COEF_MAX);
    @(negedge clk_i);

    // Directed part on reset coefficients (an oscillator on the unit
    // circle): zero, unit steps, rails, bit patterns, then runs at each
    // rail to push w, y and the output into saturation.
    samples_to_send_q.push_back(sample_t'(0));
    samples_to_send_q.push_back(sample_t'(1));
    samples_to_send_q.push_back(sample_t'(-1));
    samples_to_send_q.push_back(SAMPLE_MAX);
    samples_to_send_q.push_back(SAMPLE_MIN);
    samples_to_send_q.push_back(sample_t'(16'h5555));
    samples_to_send_q.push_back(sample_t'(16'hAAAA));
    repeat (6) samples_to_send_q.push_back(SAMPLE_MAX);
    repeat (6) samples_to_send_q.push_back(SAMPLE_MIN);
    repeat (4) samples_to_send_q.push_back(sample_t'(0));
    queue_samples(100);
    drain();

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      case (p)
        1: set_all(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        2: set_all(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        // straight pass-through
        3: set_all(COEF_ONE, '0, '0, '0, '0, COEF_ONE, COEF_ONE);
        // dead input gain, most negative output gain
        4: set_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   '0, COEF_MIN);
        8: set_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   rand_coef(), rand_coef());
        default: config_stable();
      endcase
      @(negedge clk_i);
      queue_samples(ITEMS_PER_PHASE);
      drain();
    end

    $display("Ran %0d samples over %0d coefficient sets; %0d outputs checked,",
             n_accepted, n_settings, n_checked);
    $display("%0d of them expected at a sample rail.", n_rail);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
